### rtl/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

  // character and attribute codes
  localparam logic [7:0] BLANK_CHAR        = 8'd32;
  localparam logic [7:0] NEWLINE_CODE      = 8'd10;
  localparam logic [7:0] BLANK_COLOR_RESET = 8'd151;

  // register reset values
  localparam logic [6:0] SCREEN_WIDTH_RESET  = 7'd80;
  localparam logic [4:0] SCREEN_HEIGHT_RESET = 5'd25;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_SCREEN_WIDTH,
    REG_SCREEN_HEIGHT,
    REG_BLANK_COLOR
  } cfg_reg_t;

  // classified command kinds
  typedef enum logic [1:0] {
    CMD_READ,
    CMD_PUT,
    CMD_NEWLINE
  } cmd_kind_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_COPY,
    ST_DRAIN,
    ST_FILL
  } state_t;

  typedef struct packed {
    logic [6:0] width;
    logic [4:0] height;
    logic [7:0] blank_color;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] char_code;
    logic [7:0] color;
    logic [4:0] read_row;
    logic [6:0] read_col;
    logic       read_ok;
  } cmd_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [7:0] cell_color;
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic       scrolled;
  } result_t;

endpackage

`default_nettype wire

### rtl/tcw_ram.sv
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/tcw_front.sv
`default_nettype none

module tcw_front #(
  parameter int MAX_COLS = 80,
  parameter int MAX_ROWS = 25
) (
  input  wire logic          start,
  input  wire logic          clearing,
  input  wire logic          q_full,
  input  wire logic          in_kind,
  input  wire logic [7:0]    in_char_code,
  input  wire logic [7:0]    in_color,
  input  wire logic [4:0]    in_read_row,
  input  wire logic [6:0]    in_read_col,
  output logic               busy,
  output logic               push,
  output tcw_pkg::cmd_t      cmd
);
  import tcw_pkg::*;

  // accept when the store is ready and the queue has room
  assign busy = clearing | q_full;
  assign push = start & ~busy;

  // classify the item
  always_comb begin
    cmd.char_code = in_char_code;
    cmd.color     = in_color;
    cmd.read_row  = in_read_row;
    cmd.read_col  = in_read_col;
    cmd.read_ok   = (32'(in_read_row) < MAX_ROWS) && (32'(in_read_col) < MAX_COLS);
    if (in_kind) begin
      cmd.kind = CMD_READ;
    end else if (in_char_code == NEWLINE_CODE) begin
      cmd.kind = CMD_NEWLINE;
    end else begin
      cmd.kind = CMD_PUT;
    end
  end

endmodule

`default_nettype wire

### rtl/tcw_queue.sv
`default_nettype none

module tcw_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire tcw_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output logic               q_valid,
  output logic               q_full,
  output tcw_pkg::cmd_t      q_cmd
);
  import tcw_pkg::*;

  localparam int QDEPTH = 2;
  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  cmd_t          slot_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign q_valid = (count_r != '0);
  assign q_full  = (count_r == CW'(QDEPTH));
  assign q_cmd   = slot_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == QDEPTH - 1) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == QDEPTH - 1) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

### rtl/tcw_back.sv
`default_nettype none

module tcw_back #(
  parameter int MAX_COLS = 80,
  parameter int MAX_ROWS = 25
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire tcw_pkg::cfg_t cfg,
  input  wire logic          q_valid,
  input  wire tcw_pkg::cmd_t q_cmd,
  output logic               q_pop,
  output logic               clearing,
  output logic               out_valid,
  output tcw_pkg::result_t   out_res
);
  import tcw_pkg::*;

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  function automatic logic [AW-1:0] addr_of(input logic [4:0] row, input logic [6:0] col);
    addr_of = AW'(32'(row) * MAX_COLS + 32'(col));
  endfunction

  state_t        state_r, state_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic [4:0]    row_r, row_nxt;
  logic [6:0]    col_r, col_nxt;
  logic [4:0]    cnt_row_r, cnt_row_nxt;
  logic [6:0]    cnt_col_r, cnt_col_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pend_addr_r, pend_addr_nxt;
  logic          out_valid_r;
  result_t       out_r;

  logic          emit;
  result_t       res;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;

  logic [6:0]    w;
  logic [4:0]    h;
  logic [4:0]    rowc;
  logic [6:0]    colc;
  logic          wrap, scroll;
  logic [4:0]    new_row;
  logic [6:0]    new_col;
  logic          copy_last, fill_last, clr_last;

  // columns and rows in use, clamped to the store
  always_comb begin
    if (cfg.width == '0) begin
      w = 7'd1;
    end else if (32'(cfg.width) > MAX_COLS) begin
      w = 7'(MAX_COLS);
    end else begin
      w = cfg.width;
    end
    if (cfg.height == '0) begin
      h = 5'd1;
    end else if (32'(cfg.height) > MAX_ROWS) begin
      h = 5'(MAX_ROWS);
    end else begin
      h = cfg.height;
    end
  end

  // cursor clamped into the area in use and its next position
  assign rowc    = (row_r >= h) ? h - 5'd1 : row_r;
  assign colc    = (col_r >= w) ? w - 7'd1 : col_r;
  assign wrap    = (cmd_r.kind == CMD_NEWLINE) || (colc == w - 7'd1);
  assign scroll  = wrap && (rowc == h - 5'd1);
  assign new_col = wrap ? 7'd0 : colc + 7'd1;
  assign new_row = scroll ? h - 5'd1 : (wrap ? rowc + 5'd1 : rowc);

  assign copy_last = (cnt_col_r == w - 7'd1) && (cnt_row_r == h - 5'd2);
  assign fill_last = (cnt_col_r == w - 7'd1);
  assign clr_last  = (clr_addr_r == LAST_ADDR);

  assign clearing = (state_r == ST_CLEAR);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (cmd_r.kind == CMD_READ) begin
          state_nxt = ST_RDWAIT;
        end else if (scroll) begin
          state_nxt = (h > 5'd1) ? ST_COPY : ST_FILL;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RDWAIT: state_nxt = ST_IDLE;
      ST_COPY: begin
        if (copy_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_FILL;
      ST_FILL: begin
        if (fill_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    q_pop         = 1'b0;
    emit          = 1'b0;
    res           = '0;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    cmd_nxt       = cmd_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    cnt_row_nxt   = cnt_row_r;
    cnt_col_nxt   = cnt_col_r;
    clr_addr_nxt  = clr_addr_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = {BLANK_COLOR_RESET, BLANK_CHAR};
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
        end
      end
      ST_EXEC: begin
        if (cmd_r.kind == CMD_READ) begin
          ram_re    = cmd_r.read_ok;
          ram_raddr = addr_of(cmd_r.read_row, cmd_r.read_col);
        end else begin
          if (cmd_r.kind == CMD_PUT) begin
            ram_we    = 1'b1;
            ram_waddr = addr_of(rowc, colc);
            ram_wdata = {cmd_r.color, cmd_r.char_code};
          end
          row_nxt     = new_row;
          col_nxt     = new_col;
          cnt_row_nxt = '0;
          cnt_col_nxt = '0;
          if (!scroll) begin
            emit           = 1'b1;
            res.cursor_row = new_row;
            res.cursor_col = new_col;
          end
        end
      end
      ST_RDWAIT: begin
        emit           = 1'b1;
        res.cell_char  = cmd_r.read_ok ? ram_rdata[7:0] : 8'd0;
        res.cell_color = cmd_r.read_ok ? ram_rdata[15:8] : 8'd0;
        res.cursor_row = row_r;
        res.cursor_col = col_r;
      end
      ST_COPY: begin
        // read the cell one row down, write it in the following cycle
        ram_re        = 1'b1;
        ram_raddr     = addr_of(cnt_row_r + 5'd1, cnt_col_r);
        pend_nxt      = 1'b1;
        pend_addr_nxt = addr_of(cnt_row_r, cnt_col_r);
        ram_we        = pend_r;
        ram_waddr     = pend_addr_r;
        ram_wdata     = ram_rdata;
        if (cnt_col_r == w - 7'd1) begin
          cnt_col_nxt = '0;
          cnt_row_nxt = cnt_row_r + 5'd1;
        end else begin
          cnt_col_nxt = cnt_col_r + 7'd1;
        end
      end
      ST_DRAIN: begin
        ram_we      = pend_r;
        ram_waddr   = pend_addr_r;
        ram_wdata   = ram_rdata;
        cnt_col_nxt = '0;
      end
      ST_FILL: begin
        ram_we      = 1'b1;
        ram_waddr   = addr_of(h - 5'd1, cnt_col_r);
        ram_wdata   = {cfg.blank_color, BLANK_CHAR};
        cnt_col_nxt = cnt_col_r + 7'd1;
        if (fill_last) begin
          emit           = 1'b1;
          res.cursor_row = row_r;
          res.cursor_col = col_r;
          res.scrolled   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      row_r       <= '0;
      col_r       <= '0;
      clr_addr_r  <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      clr_addr_r  <= clr_addr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= emit;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    cnt_row_r   <= cnt_row_nxt;
    cnt_col_r   <= cnt_col_nxt;
    pend_addr_r <= pend_addr_nxt;
    if (emit) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  // screen store
  tcw_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

### rtl/text_console_cell_writer.sv
`default_nettype none

// Text console with a MAX_ROWS x MAX_COLS cell store and a cursor. An item is taken when start
// is high and busy is low; each item gives exactly one result, shown for one cycle with
// out_valid, and the receiver cannot hold it off. A taken item passes through the command
// queue, the idle and execute states and, for a read, the read wait state, and its result is
// registered onto out_valid; a two-entry command queue lets up to two further items be taken
// meanwhile, so new items are accepted before earlier ones finish while the queue has room. A
// write that scrolls with more than one row in use first copies the store up one line, one
// cell per cycle; every scroll then blanks the last row, one cell per cycle, and its result
// follows. After reset, busy stays high while the store is cleared to blanks; register writes
// are taken during that time.
module text_console_cell_writer #(
  parameter int MAX_COLS = 80,
  parameter int MAX_ROWS = 25
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       in_kind,
  input  wire logic [7:0] in_char_code,
  input  wire logic [7:0] in_color,
  input  wire logic [4:0] in_read_row,
  input  wire logic [6:0] in_read_col,
  output logic            out_valid,
  output logic      [7:0] out_cell_char,
  output logic      [7:0] out_cell_color,
  output logic      [4:0] out_cursor_row,
  output logic      [6:0] out_cursor_col,
  output logic            out_scrolled,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_addr,
  input  wire logic [7:0] cfg_wdata
);
  import tcw_pkg::*;

  cfg_t    cfg_r;
  logic    clearing;
  logic    q_full, q_valid, q_pop, push;
  cmd_t    push_cmd, q_cmd;
  result_t out_res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width       <= SCREEN_WIDTH_RESET;
      cfg_r.height      <= SCREEN_HEIGHT_RESET;
      cfg_r.blank_color <= BLANK_COLOR_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_SCREEN_WIDTH:  cfg_r.width       <= cfg_wdata[6:0];
        REG_SCREEN_HEIGHT: cfg_r.height      <= cfg_wdata[4:0];
        REG_BLANK_COLOR:   cfg_r.blank_color <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // accept and classify
  tcw_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .start        (start),
    .clearing     (clearing),
    .q_full       (q_full),
    .in_kind      (in_kind),
    .in_char_code (in_char_code),
    .in_color     (in_color),
    .in_read_row  (in_read_row),
    .in_read_col  (in_read_col),
    .busy         (busy),
    .push         (push),
    .cmd          (push_cmd)
  );

  // command queue
  tcw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .q_cmd    (q_cmd)
  );

  // store sequencer
  tcw_back #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_cell_char  = out_res.cell_char;
  assign out_cell_color = out_res.cell_color;
  assign out_cursor_row = out_res.cursor_row;
  assign out_cursor_col = out_res.cursor_col;
  assign out_scrolled   = out_res.scrolled;

endmodule

`default_nettype wire

### rtl/tcw_checker.sv
`default_nettype none

module tcw_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       busy,
  input wire logic       out_valid,
  input wire logic [7:0] out_cell_char,
  input wire logic [7:0] out_cell_color,
  input wire logic [6:0] out_cursor_col
  ,
  input wire logic       out_scrolled
);

  // the store clear holds off items right after reset
  a_busy_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low in the cycle after reset");

  // no result in the cycle after reset
  a_quiet_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result transfer right after reset");

  // a scroll comes only from a write, which returns no cell
  a_scroll_no_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scrolled |-> out_cell_char == 8'd0 && out_cell_color == 8'd0)
    else $error("scrolled result carries cell data");

  // a scroll always leaves the cursor at the line start
  a_scroll_col_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scrolled |-> out_cursor_col == 7'd0)
    else $error("scrolled result with nonzero column");

endmodule

bind text_console_cell_writer tcw_checker u_tcw_checker (.*);

`default_nettype wire
